// ===== src/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg: shared types and constants of the sleep delta queue
// Entry layout, channel payloads, status codes and store commands.
// ----------------------------------------------------------------------------
package sdq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 8;
   localparam int MAX_RESULTS = 16;
   localparam int DELTA_W     = 52;
   localparam int ALU_W       = DELTA_W + 1;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
   localparam int UPT_W       = 20;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // status codes
   localparam logic [2:0] ST_QUEUED   = 3'd0;
   localparam logic [2:0] ST_NOTHING  = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_REMOVED  = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;
   localparam logic [2:0] ST_TICK     = 3'd6;

   localparam logic [UPT_W-1:0] UPT_RESET = UPT_W'(1000);
   localparam logic [31:0] NS_LIMIT  = 32'd1000000000;
   localparam logic [31:0] NS_PER_US = 32'd1000;
   localparam logic [19:0] US_PER_S  = 20'd1000000;
   // floor(ns/1000) = floor((ns>>3) * RECIP_125 >> RECIP_SHIFT) for ns < 2^30
   localparam int RECIP_SHIFT = 34;
   localparam logic [27:0] RECIP_125 = 28'd137438954;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         process_id;
      logic [7:0]         thread_id;
      logic [31:0]        wait_tag;
      logic signed [31:0] seconds;
      logic signed [31:0] nanoseconds;
      logic [15:0]        ticks;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        woke;
      logic [7:0]  woken_process;
      logic [7:0]  woken_thread;
      logic [31:0] woken_tag;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0] process_id;
      logic [ID_WIDTH-1:0] thread_id;
      logic [31:0]         tag;
      logic [DELTA_W-1:0]  delta;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DROP   = 3'd2,
      CMD_FOLD   = 3'd3,
      CMD_DELTA  = 3'd4
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [IDX_W-1:0]   idx;
      logic [IDX_W-1:0]   rd_idx;
      entry_type          wdata;
   } store_cmd_type;

endpackage

// ===== src/sdq_alu.sv =====
// ----------------------------------------------------------------------------
// sdq_alu: shared add/subtract unit
// One wide adder used by the add and subtract steps of the sequencer; borrow doubles as compare.
// ----------------------------------------------------------------------------
module sdq_alu (
   input  logic [sdq_pkg::ALU_W-1:0] a,
   input  logic [sdq_pkg::ALU_W-1:0] b,
   input  logic                      sub,
   output logic [sdq_pkg::ALU_W-1:0] y,
   output logic                      borrow
);

   logic [sdq_pkg::ALU_W:0] full;

   // add or subtract with one extra bit for carry out
   always_comb begin
      if (sub) begin
         full = {1'b0, a} - {1'b0, b};
      end else begin
         full = {1'b0, a} + {1'b0, b};
      end
   end

   assign y      = full[sdq_pkg::ALU_W-1:0];
   assign borrow = full[sdq_pkg::ALU_W];

endmodule

// ===== src/sdq_store.sv =====
// ----------------------------------------------------------------------------
// sdq_store: ordered entry storage
// Shift-register rows that open a slot on insert and close one on drop.
// ----------------------------------------------------------------------------
module sdq_store (
   input  logic                        clock,
   input  logic                        reset,
   input  sdq_pkg::store_cmd_type      cmd,
   output logic [sdq_pkg::CNT_W-1:0]   count,
   output sdq_pkg::entry_type          rd_entry,
   output sdq_pkg::entry_type          head_entry
);

   sdq_pkg::entry_type               row_ff [sdq_pkg::QUEUE_DEPTH];
   sdq_pkg::entry_type               row_in [sdq_pkg::QUEUE_DEPTH];
   logic [sdq_pkg::CNT_W-1:0]        count_ff;
   logic [sdq_pkg::CNT_W-1:0]        count_in;

   // per-row next value
   always_comb begin
      for (int j = 0; j < sdq_pkg::QUEUE_DEPTH; j++) begin
         row_in[j] = row_ff[j];
         unique case (cmd.op)
            sdq_pkg::CMD_INSERT: begin
               if (j == int'(cmd.idx)) begin
                  row_in[j] = cmd.wdata;
               end else if (j > int'(cmd.idx) && j > 0) begin
                  row_in[j] = row_ff[(j > 0) ? j - 1 : 0];
               end
            end
            sdq_pkg::CMD_DROP, sdq_pkg::CMD_FOLD: begin
               if (j >= int'(cmd.idx) && j + 1 < sdq_pkg::QUEUE_DEPTH) begin
                  row_in[j] = row_ff[(j + 1 < sdq_pkg::QUEUE_DEPTH) ? j + 1 : j];
               end
               if (cmd.op == sdq_pkg::CMD_FOLD && j == int'(cmd.idx)) begin
                  row_in[j].delta = cmd.wdata.delta;
               end
            end
            sdq_pkg::CMD_DELTA: begin
               if (j == int'(cmd.idx)) begin
                  row_in[j].delta = cmd.wdata.delta;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // fill count
   always_comb begin
      count_in = count_ff;
      unique case (cmd.op)
         sdq_pkg::CMD_INSERT:                  count_in = count_ff + 1'b1;
         sdq_pkg::CMD_DROP, sdq_pkg::CMD_FOLD: count_in = count_ff - 1'b1;
         default:                              count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < sdq_pkg::QUEUE_DEPTH; j++) begin
         row_ff[j] <= row_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count      = count_ff;
   assign rd_entry   = row_ff[cmd.rd_idx];
   assign head_entry = row_ff[0];

endmodule

// ===== src/sleep_delta_queue.sv =====
// ----------------------------------------------------------------------------
// sleep_delta_queue: delta-list timer queue of sleeping threads
// Sequencer that walks the ordered store one entry per cycle on a shared adder, unless held by a result stall.
// ----------------------------------------------------------------------------
// Steps: a rejected or unknown request goes straight to the result; insert
//   multiplies, sums, walks past earlier entries, takes the difference, writes
//   and may adjust a successor; remove finds, then drops or folds; tick
//   multiplies, then expires head entries and may trim the new head.
// Throughput: one request at a time; req_stall holds until the sequencer idles.
// Reset: synchronous; queue empties, usec_per_tick returns to 1000.
module sleep_delta_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sdq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sdq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sdq_pkg::UPT_W-1:0] csr_data
);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_INS_MUL  = 13'b0000000000010,
      S_INS_SUM  = 13'b0000000000100,
      S_INS_SCAN = 13'b0000000001000,
      S_INS_DIFF = 13'b0000000010000,
      S_INS_PUT  = 13'b0000000100000,
      S_INS_FIX  = 13'b0000001000000,
      S_RM_FIND  = 13'b0000010000000,
      S_RM_FOLD  = 13'b0000100000000,
      S_TK_MUL   = 13'b0001000000000,
      S_TK_STEP  = 13'b0010000000000,
      S_TK_FIN   = 13'b0100000000000,
      S_RESP     = 13'b1000000000000
   } state_type;

   state_type                        state_ff, state_in;
   sdq_pkg::req_type                 in_ff, in_in;
   logic [sdq_pkg::UPT_W-1:0]        upt_ff, upt_in;
   logic [sdq_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [sdq_pkg::ALU_W-1:0]        acc_ff, acc_in;
   logic [sdq_pkg::ALU_W-1:0]        target_ff, target_in;
   logic [sdq_pkg::ALU_W-1:0]        dsave_ff, dsave_in;
   logic [sdq_pkg::ALU_W-1:0]        rem_ff, rem_in;
   logic [50:0]                      prod_ff, prod_in;
   logic [20:0]                      quot_ff, quot_in;
   logic [sdq_pkg::NRES_W-1:0]       n_ff, n_in;
   logic                             pend_ff, pend_in;
   sdq_pkg::entry_type               pend_entry_ff, pend_entry_in;
   logic [2:0]                       status_ff, status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sdq_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                             accept;
   logic                             out_free;
   logic                             rsp_load;
   sdq_pkg::rsp_type                 rsp_next;
   logic [54:0]                      recip_prod;
   logic [sdq_pkg::ALU_W-1:0]        alu_a, alu_b, alu_y;
   logic                             alu_sub, alu_borrow;
   sdq_pkg::store_cmd_type           cmd;
   logic [sdq_pkg::CNT_W-1:0]        count;
   sdq_pkg::entry_type               rd_entry, head_entry, ins_entry;
   logic                             scan_go, tick_go, id_match;

   sdq_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .y      (alu_y),
      .borrow (alu_borrow)
   );

   sdq_store u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .count      (count),
      .rd_entry   (rd_entry),
      .head_entry (head_entry)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign recip_prod = 55'(in_ff.nanoseconds[29:3]) * 55'(sdq_pkg::RECIP_125);

   // entry built from the captured insert request
   always_comb begin
      ins_entry.process_id = sdq_pkg::ID_WIDTH'(in_ff.process_id);
      ins_entry.thread_id  = sdq_pkg::ID_WIDTH'(in_ff.thread_id);
      ins_entry.tag        = in_ff.wait_tag;
      ins_entry.delta      = dsave_ff[sdq_pkg::DELTA_W-1:0];
   end

   assign id_match = (rd_entry.process_id == sdq_pkg::ID_WIDTH'(in_ff.process_id)) &&
                     (rd_entry.thread_id == sdq_pkg::ID_WIDTH'(in_ff.thread_id));

   // shared adder operand selection
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_INS_SUM: begin
            alu_a = sdq_pkg::ALU_W'(prod_ff);
            alu_b = sdq_pkg::ALU_W'(quot_ff);
         end
         S_INS_SCAN: begin
            alu_a = acc_ff;
            alu_b = sdq_pkg::ALU_W'(rd_entry.delta);
         end
         S_INS_DIFF: begin
            alu_a   = target_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         S_INS_FIX: begin
            alu_a   = sdq_pkg::ALU_W'(rd_entry.delta);
            alu_b   = dsave_ff;
            alu_sub = 1'b1;
         end
         S_RM_FOLD: begin
            alu_a = sdq_pkg::ALU_W'(rd_entry.delta);
            alu_b = dsave_ff;
         end
         S_TK_STEP: begin
            alu_a   = rem_ff;
            alu_b   = sdq_pkg::ALU_W'(head_entry.delta);
            alu_sub = 1'b1;
         end
         S_TK_FIN: begin
            alu_a   = sdq_pkg::ALU_W'(head_entry.delta);
            alu_b   = rem_ff;
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign scan_go = (idx_ff < count) && (alu_y <= target_ff);
   assign tick_go = (count != '0) && (n_ff < sdq_pkg::NRES_W'(sdq_pkg::MAX_RESULTS)) &&
                    !alu_borrow;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      in_in         = in_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      target_in     = target_ff;
      dsave_in      = dsave_ff;
      rem_in        = rem_ff;
      prod_in       = prod_ff;
      quot_in       = quot_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_entry_in = pend_entry_ff;
      status_in     = status_ff;
      rsp_load      = 1'b0;
      rsp_next      = '0;
      cmd           = '0;
      cmd.op        = sdq_pkg::CMD_NONE;
      cmd.rd_idx    = idx_ff[sdq_pkg::IDX_W-1:0];
      cmd.idx       = idx_ff[sdq_pkg::IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               in_in  = req_data;
               idx_in = '0;
               acc_in = '0;
               n_in   = '0;
               pend_in = 1'b0;
               unique case (req_data.op)
                  sdq_pkg::OP_INSERT: begin
                     if (req_data.seconds[31]) begin
                        status_in = sdq_pkg::ST_NOTHING;
                        state_in  = S_RESP;
                     end else if (req_data.nanoseconds[31] ||
                                  $unsigned(req_data.nanoseconds) >= sdq_pkg::NS_LIMIT) begin
                        status_in = sdq_pkg::ST_INVALID;
                        state_in  = S_RESP;
                     end else if (req_data.seconds == 32'sd0 &&
                                  $unsigned(req_data.nanoseconds) < sdq_pkg::NS_PER_US) begin
                        status_in = sdq_pkg::ST_NOTHING;
                        state_in  = S_RESP;
                     end else if (count >= sdq_pkg::CNT_W'(sdq_pkg::QUEUE_DEPTH)) begin
                        status_in = sdq_pkg::ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_INS_MUL;
                     end
                  end
                  sdq_pkg::OP_REMOVE: state_in = S_RM_FIND;
                  sdq_pkg::OP_TICK:   state_in = S_TK_MUL;
                  default: begin
                     status_in = sdq_pkg::ST_NOTHING;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         // seconds to microseconds, nanoseconds by reciprocal
         S_INS_MUL: begin
            prod_in  = 51'(in_ff.seconds[30:0]) * 51'(sdq_pkg::US_PER_S);
            quot_in  = recip_prod[54:sdq_pkg::RECIP_SHIFT];
            state_in = S_INS_SUM;
         end
         S_INS_SUM: begin
            target_in = alu_y;
            state_in  = S_INS_SCAN;
         end
         // walk past entries that wake no later than the request
         S_INS_SCAN: begin
            if (scan_go) begin
               acc_in = alu_y;
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_INS_DIFF;
            end
         end
         S_INS_DIFF: begin
            dsave_in = alu_y;
            state_in = S_INS_PUT;
         end
         S_INS_PUT: begin
            cmd.op    = sdq_pkg::CMD_INSERT;
            cmd.wdata = ins_entry;
            status_in = sdq_pkg::ST_QUEUED;
            if (idx_ff < count) begin
               state_in = S_INS_FIX;
            end else begin
               state_in = S_RESP;
            end
         end
         // successor loses the new entry's delta
         S_INS_FIX: begin
            cmd.rd_idx      = sdq_pkg::IDX_W'(idx_ff + 1'b1);
            cmd.idx         = sdq_pkg::IDX_W'(idx_ff + 1'b1);
            cmd.op          = sdq_pkg::CMD_DELTA;
            cmd.wdata.delta = alu_y[sdq_pkg::DELTA_W-1:0];
            state_in        = S_RESP;
         end
         // search by process and thread
         S_RM_FIND: begin
            if (idx_ff >= count) begin
               status_in = sdq_pkg::ST_NOTFOUND;
               state_in  = S_RESP;
            end else if (id_match) begin
               dsave_in  = sdq_pkg::ALU_W'(rd_entry.delta);
               status_in = sdq_pkg::ST_REMOVED;
               if (idx_ff + 1'b1 < count) begin
                  state_in = S_RM_FOLD;
               end else begin
                  cmd.op   = sdq_pkg::CMD_DROP;
                  state_in = S_RESP;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         // fold removed delta into successor while closing the gap
         S_RM_FOLD: begin
            cmd.rd_idx      = sdq_pkg::IDX_W'(idx_ff + 1'b1);
            cmd.op          = sdq_pkg::CMD_FOLD;
            cmd.wdata.delta = alu_y[sdq_pkg::DELTA_W-1:0];
            state_in        = S_RESP;
         end
         S_TK_MUL: begin
            rem_in   = sdq_pkg::ALU_W'(upt_ff) * sdq_pkg::ALU_W'(in_ff.ticks);
            state_in = S_TK_STEP;
         end
         // expire head entries, one per cycle while no result stall holds; pending one goes out a step later
         S_TK_STEP: begin
            cmd.idx = '0;
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_load               = 1'b1;
                  rsp_next.status        = sdq_pkg::ST_TICK;
                  rsp_next.woke          = 1'b1;
                  rsp_next.woken_process = 8'(pend_entry_ff.process_id);
                  rsp_next.woken_thread  = 8'(pend_entry_ff.thread_id);
                  rsp_next.woken_tag     = pend_entry_ff.tag;
                  rsp_next.last_result   = !tick_go;
               end
               status_in = sdq_pkg::ST_TICK;
               if (tick_go) begin
                  pend_in       = 1'b1;
                  pend_entry_in = head_entry;
                  rem_in        = alu_y;
                  n_in          = n_ff + 1'b1;
                  cmd.op        = sdq_pkg::CMD_DROP;
               end else begin
                  pend_in = 1'b0;
                  if (count != '0) begin
                     state_in = S_TK_FIN;
                  end else if (n_ff == '0) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         // leftover time comes off the new head, floored at zero
         S_TK_FIN: begin
            cmd.idx         = '0;
            cmd.op          = sdq_pkg::CMD_DELTA;
            cmd.wdata.delta = alu_borrow ? '0 : alu_y[sdq_pkg::DELTA_W-1:0];
            state_in        = (n_ff == '0) ? S_RESP : S_IDLE;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_next.status      = status_ff;
               rsp_next.last_result = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_data_in  = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   // configuration register
   assign upt_in = (csr_valid && csr_ready) ? csr_data : upt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         upt_ff       <= sdq_pkg::UPT_RESET;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         upt_ff       <= upt_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff         <= in_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      target_ff     <= target_in;
      dsave_ff      <= dsave_in;
      rem_ff        <= rem_in;
      prod_ff       <= prod_in;
      quot_ff       <= quot_in;
      pend_entry_ff <= pend_entry_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= sdq_pkg::CNT_W'(sdq_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_woke_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.woke |-> rsp_data.status == sdq_pkg::ST_TICK)
      else $error("wake result without tick status");

   a_state_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_expiry_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= sdq_pkg::NRES_W'(sdq_pkg::MAX_RESULTS))
      else $error("too many expiries in one tick");

endmodule
